// ===== rtl/gst_pkg.sv =====
`timescale 1ns / 1ps

package gst_pkg;

  localparam int CMD_W     = 2;
  localparam int FD_W      = 16;
  localparam int HANDLER_W = 16;
  localparam int TOKEN_W   = 64;
  localparam int GEN_W     = 32;
  localparam int MASK_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int MAXFD_W   = 13;

  localparam logic [MAXFD_W-1:0] MAXFD_RESET = 13'h1FFF;

  localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVENT      = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 3'd0,
    STATUS_FD_RANGE     = 3'd1,
    STATUS_DUPLICATE    = 3'd2,
    STATUS_NULL_HANDLER = 3'd3,
    STATUS_EXHAUSTED    = 3'd4,
    STATUS_IGNORED      = 3'd5,
    STATUS_STALE        = 3'd6
  } gst_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_SLOT,
    S_COMMIT
  } gst_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [FD_W-1:0]  fd;
    logic [HANDLER_W-1:0]    handler_id;
    logic [TOKEN_W-1:0]      token;
    logic [MASK_W-1:0]       event_mask;
  } gst_item_t;

  typedef struct packed {
    gst_status_e             status;
    logic [TOKEN_W-1:0]      out_token;
    logic                    dispatch_valid;
    logic [HANDLER_W-1:0]    dispatch_handler;
    logic [MASK_W-1:0]       dispatch_mask;
  } gst_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic cap;
    logic slot_rd;
    logic commit;
  } gst_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic unreg_hit;
    logic out_busy;
  } gst_sts_t;

endpackage

// ===== rtl/gst_in_if.sv =====
`timescale 1ns / 1ps

interface gst_in_if
  import gst_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic signed [FD_W-1:0] fd;
  logic [HANDLER_W-1:0]   handler_id;
  logic [TOKEN_W-1:0]     token;
  logic [MASK_W-1:0]      event_mask;

  modport source (output valid, cmd, fd, handler_id, token, event_mask, input ready);
  modport sink (input valid, cmd, fd, handler_id, token, event_mask, output ready);
endinterface

// ===== rtl/gst_out_if.sv =====
`timescale 1ns / 1ps

interface gst_out_if
  import gst_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [TOKEN_W-1:0]   out_token;
  logic                 dispatch_valid;
  logic [HANDLER_W-1:0] dispatch_handler;
  logic [MASK_W-1:0]    dispatch_mask;

  modport source (output valid, status, out_token, dispatch_valid, dispatch_handler,
                  dispatch_mask, input ready);
  modport sink (input valid, status, out_token, dispatch_valid, dispatch_handler,
                dispatch_mask, output ready);
endinterface

// ===== rtl/gst_ctrl.sv =====
`timescale 1ns / 1ps

module gst_ctrl
  import gst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gst_sts_t sts_i,
  output gst_ctl_t ctl_o
);

  gst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.cap = 1'b1;
          state_d   = S_FETCH;
        end
      end
      S_FETCH: begin
        // An unregister that finds a mapping still has to read its slot.
        if (sts_i.unreg_hit) begin
          ctl_o.slot_rd = 1'b1;
          state_d       = S_SLOT;
        end else if (!sts_i.out_busy) begin
          ctl_o.commit = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_SLOT, S_COMMIT: begin
        if (!sts_i.out_busy) begin
          ctl_o.commit = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_COMMIT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_commit_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |-> !sts_i.out_busy)
    else $error("commit while the result register is still occupied");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new item taken while an item is in progress");

  a_commit_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |=> in_ready_o)
    else $error("block not ready after commit");
`endif

endmodule

// ===== rtl/gst_datapath.sv =====
`timescale 1ns / 1ps

module gst_datapath
  import gst_pkg::*;
#(
  parameter int SLOT_COUNT = 1024,
  parameter int FD_ENTRIES = 8192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MAXFD_W-1:0] cfg_wdata_i,
  input  gst_ctl_t           ctl_i,
  output gst_sts_t           sts_o,
  input  gst_item_t          item_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output gst_result_t        res_o
);

  localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FW   = (FD_ENTRIES > 1) ? $clog2(FD_ENTRIES) : 1;
  localparam int MAXD = (SLOT_COUNT > FD_ENTRIES) ? SLOT_COUNT : FD_ENTRIES;
  localparam int CW   = (MAXD > 1) ? $clog2(MAXD) : 1;

  typedef struct packed {
    logic [GEN_W-1:0]     gen;
    logic [HANDLER_W-1:0] handler;
    logic [FD_W-1:0]      owner;
    logic [SW-1:0]        link;
    logic                 link_valid;
  } slot_word_t;

  typedef struct packed {
    logic          valid;
    logic [SW-1:0] slot;
  } map_word_t;

  slot_word_t slot_mem [SLOT_COUNT];
  map_word_t  map_mem  [FD_ENTRIES];

  logic [MAXFD_W-1:0] max_fd_q;
  logic [CW-1:0]      clr_cnt_q;
  logic [SW-1:0]      free_head_q, free_head_d;
  logic               free_valid_q, free_valid_d;
  gst_item_t          item_q;
  slot_word_t         slot_rd_q;
  map_word_t          map_rd_q;
  logic               out_valid_q;
  gst_result_t        res_q, res_d;

  logic [CW:0]        clr_inc;
  logic               clr_slot, clr_map;
  logic               in_range, reg_ok, unreg_ok;
  logic [FD_W-2:0]    fd_lo;

  logic               slot_re, slot_we;
  logic [SW-1:0]      slot_raddr, slot_waddr;
  slot_word_t         slot_wdata;
  logic               map_we;
  logic [FW-1:0]      map_waddr;
  map_word_t          map_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fd_q <= MAXFD_RESET;
    end else if (cfg_we_i) begin
      max_fd_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctl_i.clr_wr) begin
      clr_cnt_q <= clr_inc[CW-1:0];
    end
  end

  assign clr_inc  = {1'b0, clr_cnt_q} + 1'b1;
  assign clr_slot = ({1'b0, clr_cnt_q} < (CW+1)'(SLOT_COUNT));
  assign clr_map  = ({1'b0, clr_cnt_q} < (CW+1)'(FD_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      item_q <= item_i;
    end
  end

  // Descriptor range check against the live limit and the table size.
  assign fd_lo    = item_q.fd[FD_W-2:0];
  assign in_range = !item_q.fd[FD_W-1]
                    && (fd_lo <= (FD_W-1)'(max_fd_q))
                    && ({1'b0, fd_lo} < FD_W'(FD_ENTRIES));

  always_comb begin
    res_d    = '0;
    reg_ok   = 1'b0;
    unreg_ok = 1'b0;
    res_d.status = STATUS_IGNORED;
    case (item_q.cmd)
      CMD_REGISTER: begin
        if (!in_range) begin
          res_d.status = STATUS_FD_RANGE;
        end else if (map_rd_q.valid) begin
          res_d.status = STATUS_DUPLICATE;
        end else if (item_q.handler_id == '0) begin
          res_d.status = STATUS_NULL_HANDLER;
        end else if (!free_valid_q) begin
          res_d.status = STATUS_EXHAUSTED;
        end else begin
          reg_ok          = 1'b1;
          res_d.status    = STATUS_OK;
          res_d.out_token = {slot_rd_q.gen, {(32-SW){1'b0}}, free_head_q};
        end
      end
      CMD_UNREGISTER: begin
        if (in_range && map_rd_q.valid && (slot_rd_q.owner == item_q.fd)) begin
          unreg_ok     = 1'b1;
          res_d.status = STATUS_OK;
        end
      end
      CMD_EVENT: begin
        res_d.status = STATUS_STALE;
        if ((item_q.token[31:0] < 32'(SLOT_COUNT))
            && (slot_rd_q.gen == item_q.token[TOKEN_W-1:32])
            && (slot_rd_q.handler != '0)) begin
          res_d.status           = STATUS_OK;
          res_d.dispatch_valid   = 1'b1;
          res_d.dispatch_handler = slot_rd_q.handler;
          res_d.dispatch_mask    = item_q.event_mask;
        end
      end
      default: begin
        res_d.status = STATUS_IGNORED;
      end
    endcase
  end

  // Slot memory ports: clearing pass, then read at capture or after the map lookup.
  always_comb begin
    slot_re    = ctl_i.cap || ctl_i.slot_rd;
    slot_raddr = map_rd_q.slot;
    if (ctl_i.cap) begin
      slot_raddr = (item_i.cmd == CMD_EVENT) ? item_i.token[SW-1:0] : free_head_q;
    end
    slot_we    = 1'b0;
    slot_waddr = clr_cnt_q[SW-1:0];
    slot_wdata = '{gen: '0, handler: '0, owner: '1,
                   link: clr_inc[SW-1:0], link_valid: (clr_inc < (CW+1)'(SLOT_COUNT))};
    if (ctl_i.clr_wr) begin
      slot_we = clr_slot;
    end else if (ctl_i.commit && reg_ok) begin
      slot_we    = 1'b1;
      slot_waddr = free_head_q;
      slot_wdata = slot_rd_q;
      slot_wdata.handler    = item_q.handler_id;
      slot_wdata.owner      = item_q.fd;
      slot_wdata.link_valid = 1'b0;
    end else if (ctl_i.commit && unreg_ok) begin
      slot_we    = 1'b1;
      slot_waddr = map_rd_q.slot;
      slot_wdata = '{gen: slot_rd_q.gen + 32'd1, handler: '0, owner: '1,
                     link: free_head_q, link_valid: free_valid_q};
    end
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_cnt_q[FW-1:0];
    map_wdata = '0;
    if (ctl_i.clr_wr) begin
      map_we = clr_map;
    end else if (ctl_i.commit && (reg_ok || unreg_ok)) begin
      map_we    = 1'b1;
      map_waddr = item_q.fd[FW-1:0];
      if (reg_ok) begin
        map_wdata = '{valid: 1'b1, slot: free_head_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (ctl_i.cap) begin
      map_rd_q <= map_mem[item_i.fd[FW-1:0]];
    end
  end

  always_comb begin
    free_head_d  = free_head_q;
    free_valid_d = free_valid_q;
    if (ctl_i.commit && reg_ok) begin
      free_head_d  = slot_rd_q.link;
      free_valid_d = slot_rd_q.link_valid;
    end else if (ctl_i.commit && unreg_ok) begin
      free_head_d  = map_rd_q.slot;
      free_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= '0;
      free_valid_q <= 1'b1;
    end else begin
      free_head_q  <= free_head_d;
      free_valid_q <= free_valid_d;
    end
  end

  // Result register: the next item can be taken while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign res_o           = res_q;
  assign sts_o.clr_done  = (clr_cnt_q == CW'(MAXD - 1));
  assign sts_o.unreg_hit = (item_q.cmd == CMD_UNREGISTER) && in_range && map_rd_q.valid;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

`ifndef SYNTHESIS
  a_dispatch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.dispatch_valid) |-> (res_q.status == STATUS_OK))
    else $error("dispatch without ok status");

  a_token_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.status != STATUS_OK)) |-> (res_q.out_token == '0))
    else $error("token issued on a failed operation");

  a_free_after_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.commit && unreg_ok) |=> (free_valid_q && (free_head_q == $past(map_rd_q.slot))))
    else $error("released slot not at the free list head");
`endif

endmodule

// ===== rtl/generational_slot_table.sv =====
`timescale 1ns / 1ps

// Handle table with a free-list slot pool and a generation count per slot.
// Commands arrive on req_i (valid/ready); one result per command leaves on
// rsp_o (valid/ready). A transfer happens when valid and ready are both high.
// Register returns a token {generation, slot}; unregister frees the slot and
// bumps its generation; an event with a current token returns the handler and
// the mask, a stale token returns the stale status.
// Each command passes through the fetch state, and an unregister that finds a
// mapping also through the slot-read state, before its result is committed.
// One command is in work at a time, so the next is taken only after commit;
// each command reads then writes the single-port slot and descriptor memories.
// A finished result sits in an output register, and the next command is taken
// while it waits. If the receiver stalls with a result still held, the next
// command completes its lookup and then waits until that register empties.
// After reset both memories are swept, one entry per cycle, across all
// max(SLOT_COUNT, FD_ENTRIES) entries (8192 by default), while req_i.ready is
// low. The user sets max_fd (cfg_we_i/cfg_wdata_i) only while idle; unchecked.
module generational_slot_table
  import gst_pkg::*;
#(
  parameter int SLOT_COUNT = 1024,
  parameter int FD_ENTRIES = 8192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MAXFD_W-1:0] cfg_wdata_i,
  gst_in_if.sink             req_i,
  gst_out_if.source          rsp_o
);

  gst_ctl_t    ctl;
  gst_sts_t    sts;
  gst_item_t   item;
  gst_result_t res;
  logic        in_ready;
  logic        out_valid;

  assign item.cmd        = req_i.cmd;
  assign item.fd         = req_i.fd;
  assign item.handler_id = req_i.handler_id;
  assign item.token      = req_i.token;
  assign item.event_mask = req_i.event_mask;
  assign req_i.ready     = in_ready;

  gst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  gst_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .FD_ENTRIES (FD_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .item_i      (item),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign rsp_o.valid            = out_valid;
  assign rsp_o.status           = res.status;
  assign rsp_o.out_token        = res.out_token;
  assign rsp_o.dispatch_valid   = res.dispatch_valid;
  assign rsp_o.dispatch_handler = res.dispatch_handler;
  assign rsp_o.dispatch_mask    = res.dispatch_mask;

endmodule
